// ===== hdl/joystick_teleop_command_engine_macros.svh =====
// Assertion helpers for the joystick teleop command engine.
// Each macro expects a clk and a rst signal in the calling scope.
`ifndef JOYSTICK_TELEOP_COMMAND_ENGINE_MACROS_SVH
`define JOYSTICK_TELEOP_COMMAND_ENGINE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define JTCE_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define JTCE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/jtce_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtce_pkg
// Shared types, codes and constants of the joystick teleop command engine.
// ----------------------------------------------------------------------------
package jtce_pkg;

  localparam int NUM_BUTTONS_DEF   = 16;
  localparam int MAX_BEHAVIORS_DEF = 16;
  localparam int IndexSpan         = 16;

  localparam int AXIS_W  = 16;
  localparam int BTN_W   = 16;
  localparam int BIDX_W  = 4;
  localparam int BCNT_W  = 5;
  localparam int ACC_W   = 24;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 5;

  // Register indexes of the configuration port
  localparam logic [CFG_AW-1:0] CFG_ESTOP_IDX    = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_ACTIVATE_IDX = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_USER_IDX     = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_BEH_COUNT    = 2'd3;

  // Reset values of the configuration registers
  localparam logic [BIDX_W-1:0] RST_ESTOP_IDX    = 4'd1;
  localparam logic [BIDX_W-1:0] RST_ACTIVATE_IDX = 4'd0;
  localparam logic [BIDX_W-1:0] RST_USER_IDX     = 4'd3;
  localparam logic [BCNT_W-1:0] RST_BEH_COUNT    = 5'd1;

  // Command codes
  localparam logic [1:0] ACT_NONE       = 2'd0;
  localparam logic [1:0] ACT_ACTIVATE   = 2'd1;
  localparam logic [1:0] ACT_DEACTIVATE = 2'd2;
  localparam logic [1:0] ESTOP_NONE     = 2'd0;
  localparam logic [1:0] ESTOP_ASSERT   = 2'd1;
  localparam logic [1:0] ESTOP_RELEASE  = 2'd2;

  // Fixed button bits and trigger constants
  localparam logic [3:0] TILT_UP_BIT   = 4'd5;
  localparam logic [3:0] TILT_DOWN_BIT = 4'd4;
  localparam logic signed [AXIS_W-1:0] TRIGGER_REST = 16'sd32767;
  localparam logic signed [2:0] HEIGHT_STEP = 3'sd2;
  localparam logic signed [2:0] TILT_STEP   = 3'sd1;

  typedef struct packed {
    logic [BIDX_W-1:0] estop_idx;
    logic [BIDX_W-1:0] activate_idx;
    logic [BIDX_W-1:0] user_idx;
    logic [BCNT_W-1:0] behavior_count;
  } jtce_cfg_t;

  typedef struct packed {
    logic        [BTN_W-1:0]  buttons;
    logic signed [AXIS_W-1:0] behavior_axis;
    logic signed [AXIS_W-1:0] turn_axis;
    logic signed [AXIS_W-1:0] speed_axis;
    logic signed [AXIS_W-1:0] raise_trigger;
    logic signed [AXIS_W-1:0] lower_trigger;
  } jtce_sample_t;

  typedef struct packed {
    logic        [1:0]        activate_cmd;
    logic        [1:0]        estop_cmd;
    logic                     user_input_pulse;
    logic                     behavior_valid;
    logic        [BIDX_W-1:0] behavior_index;
    logic                     drive_valid;
    logic signed [AXIS_W-1:0] drive_turn;
    logic signed [AXIS_W-1:0] drive_speed;
    logic                     hitch_valid;
    logic signed [ACC_W-1:0]  hitch_height;
    logic signed [ACC_W-1:0]  hitch_tilt;
  } jtce_cmd_t;

  typedef struct packed {
    logic                     stop_latched;
    logic                     estop_armed;
    logic                     estop_held;
    logic                     activated;
    logic                     activate_held;
    logic                     user_held;
    logic                     axis_held;
    logic        [BIDX_W-1:0] current_behavior;
    logic signed [AXIS_W-1:0] last_turn;
    logic signed [AXIS_W-1:0] last_speed;
    logic signed [ACC_W-1:0]  height_acc;
    logic signed [ACC_W-1:0]  tilt_acc;
  } jtce_state_t;

endpackage

// ===== hdl/jtce_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtce channels
// Valid/ready channel interfaces: joystick sample in, command record out,
// and the configuration write channel.
// ----------------------------------------------------------------------------
interface jtce_sample_if;
  import jtce_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [BTN_W-1:0]  buttons;
  logic signed [AXIS_W-1:0] behavior_axis;
  logic signed [AXIS_W-1:0] turn_axis;
  logic signed [AXIS_W-1:0] speed_axis;
  logic signed [AXIS_W-1:0] raise_trigger;
  logic signed [AXIS_W-1:0] lower_trigger;
  modport source(output valid, buttons, behavior_axis, turn_axis, speed_axis,
                 raise_trigger, lower_trigger, input ready);
  modport sink(input valid, buttons, behavior_axis, turn_axis, speed_axis,
               raise_trigger, lower_trigger, output ready);
endinterface

interface jtce_cmd_if;
  import jtce_pkg::*;
  logic                     valid;
  logic                     ready;
  logic        [1:0]        activate_cmd;
  logic        [1:0]        estop_cmd;
  logic                     user_input_pulse;
  logic                     behavior_valid;
  logic        [BIDX_W-1:0] behavior_index;
  logic                     drive_valid;
  logic signed [AXIS_W-1:0] drive_turn;
  logic signed [AXIS_W-1:0] drive_speed;
  logic                     hitch_valid;
  logic signed [ACC_W-1:0]  hitch_height;
  logic signed [ACC_W-1:0]  hitch_tilt;
  modport source(output valid, activate_cmd, estop_cmd, user_input_pulse,
                 behavior_valid, behavior_index, drive_valid, drive_turn,
                 drive_speed, hitch_valid, hitch_height, hitch_tilt,
                 input ready);
  modport sink(input valid, activate_cmd, estop_cmd, user_input_pulse,
               behavior_valid, behavior_index, drive_valid, drive_turn,
               drive_speed, hitch_valid, hitch_height, hitch_tilt,
               output ready);
endinterface

interface jtce_cfg_if;
  import jtce_pkg::*;
  logic              valid;
  logic              ready;
  logic [CFG_AW-1:0] index;
  logic [CFG_DW-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== hdl/jtce_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtce_cfg_regs
// Configuration register file: button indexes and behavior count.
// ----------------------------------------------------------------------------
module jtce_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  jtce_cfg_if.sink           cfg,
  output jtce_pkg::jtce_cfg_t regs
);
  import jtce_pkg::*;

  jtce_cfg_t cfg_q;

  assign cfg.ready = 1'b1;
  assign regs      = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.estop_idx      <= RST_ESTOP_IDX;
      cfg_q.activate_idx   <= RST_ACTIVATE_IDX;
      cfg_q.user_idx       <= RST_USER_IDX;
      cfg_q.behavior_count <= RST_BEH_COUNT;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_ESTOP_IDX:    cfg_q.estop_idx      <= cfg.data[BIDX_W-1:0];
        CFG_ACTIVATE_IDX: cfg_q.activate_idx   <= cfg.data[BIDX_W-1:0];
        CFG_USER_IDX:     cfg_q.user_idx       <= cfg.data[BIDX_W-1:0];
        CFG_BEH_COUNT:    cfg_q.behavior_count <= cfg.data;
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hdl/jtce_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtce_step
// Next-state and command logic for one joystick sample.
// ----------------------------------------------------------------------------
module jtce_step #(
  parameter int NUM_BUTTONS   = jtce_pkg::NUM_BUTTONS_DEF,
  parameter int MAX_BEHAVIORS = jtce_pkg::MAX_BEHAVIORS_DEF
) (
  input  jtce_pkg::jtce_cfg_t    cfg,
  input  jtce_pkg::jtce_sample_t smp,
  input  jtce_pkg::jtce_state_t  st,
  output jtce_pkg::jtce_state_t  st_next,
  output jtce_pkg::jtce_cmd_t    res
);
  import jtce_pkg::*;

  localparam int LimitCount = (MAX_BEHAVIORS < IndexSpan) ? MAX_BEHAVIORS : IndexSpan;
  localparam logic [BCNT_W-1:0] CountLimit = BCNT_W'(LimitCount);

  // Buttons at or beyond the button count read as released.
  function automatic logic btn(input logic [BTN_W-1:0] map, input logic [3:0] idx);
    btn = (int'(idx) < NUM_BUTTONS) ? map[idx] : 1'b0;
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_step(
      input logic signed [ACC_W-1:0] acc, input logic signed [2:0] d);
    logic [ACC_W:0] s;
    s = {acc[ACC_W-1], acc} + {{(ACC_W-2){d[2]}}, d};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_step = s[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
    end else begin
      sat_step = s[ACC_W-1:0];
    end
  endfunction

  logic              ep, ap, up, tu, td, rp, lp;
  logic              axis_zero, trig_ok;
  logic [BCNT_W-1:0] beh_n;
  logic [BCNT_W-1:0] beh_up;
  logic [BCNT_W-1:0] beh_dn;
  logic              beh_ok;
  logic signed [ACC_W-1:0] nh, nt;
  jtce_state_t       ns;
  jtce_cmd_t         r;

  assign ep = btn(smp.buttons, cfg.estop_idx);
  assign ap = btn(smp.buttons, cfg.activate_idx);
  assign up = btn(smp.buttons, cfg.user_idx);
  assign tu = btn(smp.buttons, TILT_UP_BIT);
  assign td = btn(smp.buttons, TILT_DOWN_BIT);
  assign rp = smp.raise_trigger < TRIGGER_REST;
  assign lp = smp.lower_trigger < TRIGGER_REST;
  assign axis_zero = (smp.behavior_axis == '0);
  assign trig_ok   = (smp.raise_trigger != '0) && (smp.lower_trigger != '0);

  assign beh_n  = (cfg.behavior_count > CountLimit) ? CountLimit : cfg.behavior_count;
  assign beh_ok = (beh_n != '0) && ({1'b0, st.current_behavior} < beh_n);
  assign beh_up = ({1'b0, st.current_behavior} + 1'b1 == beh_n) ? '0
                : {1'b0, st.current_behavior} + 1'b1;
  assign beh_dn = (st.current_behavior == '0) ? beh_n - 1'b1
                : {1'b0, st.current_behavior} - 1'b1;

  always_comb begin
    ns = st;
    nh = st.height_acc;
    nt = st.tilt_acc;
    r  = '0;
    r.activate_cmd = ACT_NONE;
    r.estop_cmd    = ESTOP_NONE;

    if (ep && !st.estop_armed && !st.estop_held) begin
      // Stop press: latch and skip everything else for this sample.
      ns.stop_latched = 1'b1;
      ns.estop_held   = 1'b1;
      r.activate_cmd  = ACT_DEACTIVATE;
      r.estop_cmd     = ESTOP_ASSERT;
    end else begin
      if (!ep && !st.estop_armed && st.estop_held) begin
        ns.activated   = 1'b0;
        ns.estop_armed = 1'b1;
        ns.estop_held  = 1'b0;
      end else if (ep && st.estop_armed && !st.estop_held) begin
        ns.stop_latched = 1'b0;
        ns.estop_held   = 1'b1;
        r.estop_cmd     = ESTOP_RELEASE;
      end else if (!ep && st.estop_armed && st.estop_held) begin
        ns.estop_armed = 1'b0;
        ns.estop_held  = 1'b0;
      end

      if (up && !st.user_held) begin
        r.user_input_pulse = 1'b1;
        ns.user_held       = 1'b1;
      end else if (!up && st.user_held) begin
        ns.user_held = 1'b0;
      end

      if (!ns.stop_latched) begin
        if (!axis_zero && !st.axis_held) begin
          if (beh_ok) begin
            ns.current_behavior = smp.behavior_axis[AXIS_W-1] ? beh_dn[BIDX_W-1:0]
                                                               : beh_up[BIDX_W-1:0];
            r.behavior_valid = 1'b1;
          end
          ns.axis_held = 1'b1;
        end else if (axis_zero && st.axis_held) begin
          ns.axis_held = 1'b0;
        end

        if (ap && !st.activate_held) begin
          r.activate_cmd   = ns.activated ? ACT_DEACTIVATE : ACT_ACTIVATE;
          ns.activate_held = 1'b1;
        end else if (!ap && st.activate_held) begin
          ns.activated     = !ns.activated;
          ns.activate_held = 1'b0;
        end

        if (ns.activated) begin
          if (smp.turn_axis != st.last_turn || smp.speed_axis != st.last_speed) begin
            ns.last_turn  = smp.turn_axis;
            ns.last_speed = smp.speed_axis;
            r.drive_valid = 1'b1;
          end
          if (trig_ok) begin
            if (rp && !lp) begin
              nh = sat_step(st.height_acc, HEIGHT_STEP);
            end else if (lp && !rp) begin
              nh = sat_step(st.height_acc, -HEIGHT_STEP);
            end
            if (tu && !td) begin
              nt = sat_step(st.tilt_acc, TILT_STEP);
            end else if (td && !tu) begin
              nt = sat_step(st.tilt_acc, -TILT_STEP);
            end
            r.hitch_valid = (nh != st.height_acc) || (nt != st.tilt_acc);
            ns.height_acc = nh;
            ns.tilt_acc   = nt;
          end
        end
      end
    end

    r.behavior_index = ns.current_behavior;
    r.drive_turn     = ns.last_turn;
    r.drive_speed    = ns.last_speed;
    r.hitch_height   = ns.height_acc;
    r.hitch_tilt     = ns.tilt_acc;
  end

  assign st_next = ns;
  assign res     = r;

endmodule

// ===== hdl/joystick_teleop_command_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joystick_teleop_command_engine
// Turns joystick samples into command records: soft stop, activation,
// behavior select, drive values and hitch height/tilt.
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  sample   in   valid/ready   buttons, behavior axis, drive axes, triggers
//  cmd      out  valid/ready   one command record per sample
//  cfg      in   valid/ready   register index (2b), write data (5b)
//
// One sample per cycle sustained while cmd is ready; cmd valid rises once the
// sample has passed the input register and then the result register.
// Command state updates in the single pass from input to result register.
// A stalled cmd holds the result register; the input register still takes
// one more sample, then sample.ready drops until cmd transfers.
// Synchronous active-high reset clears all command state and both valids.
// ----------------------------------------------------------------------------
`include "joystick_teleop_command_engine_macros.svh"

module joystick_teleop_command_engine #(
  parameter int NUM_BUTTONS   = jtce_pkg::NUM_BUTTONS_DEF,
  parameter int MAX_BEHAVIORS = jtce_pkg::MAX_BEHAVIORS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  jtce_sample_if.sink   sample,
  jtce_cmd_if.source    cmd,
  jtce_cfg_if.sink      cfg
);
  import jtce_pkg::*;

  jtce_cfg_t    regs;
  jtce_sample_t smp_q;
  logic         smp_valid;
  jtce_state_t  st_q;
  jtce_state_t  st_next;
  jtce_cmd_t    res;
  jtce_cmd_t    cmd_q;
  logic         cmd_valid;
  logic         advance;

  jtce_cfg_regs u_cfg (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  jtce_step #(
    .NUM_BUTTONS   (NUM_BUTTONS),
    .MAX_BEHAVIORS (MAX_BEHAVIORS)
  ) u_step (
    .cfg     (regs),
    .smp     (smp_q),
    .st      (st_q),
    .st_next (st_next),
    .res     (res)
  );

  // Move the held sample into the result register when that slot frees up.
  assign advance      = smp_valid && (!cmd_valid || cmd.ready);
  assign sample.ready = !smp_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      smp_valid <= 1'b1;
    end else if (advance) begin
      smp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      smp_q.buttons       <= sample.buttons;
      smp_q.behavior_axis <= sample.behavior_axis;
      smp_q.turn_axis     <= sample.turn_axis;
      smp_q.speed_axis    <= sample.speed_axis;
      smp_q.raise_trigger <= sample.raise_trigger;
      smp_q.lower_trigger <= sample.lower_trigger;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_q <= '0;
    end else if (advance) begin
      st_q <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (advance) begin
      cmd_valid <= 1'b1;
    end else if (cmd.ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cmd_q <= res;
    end
  end

  assign cmd.valid            = cmd_valid;
  assign cmd.activate_cmd     = cmd_q.activate_cmd;
  assign cmd.estop_cmd        = cmd_q.estop_cmd;
  assign cmd.user_input_pulse = cmd_q.user_input_pulse;
  assign cmd.behavior_valid   = cmd_q.behavior_valid;
  assign cmd.behavior_index   = cmd_q.behavior_index;
  assign cmd.drive_valid      = cmd_q.drive_valid;
  assign cmd.drive_turn       = cmd_q.drive_turn;
  assign cmd.drive_speed      = cmd_q.drive_speed;
  assign cmd.hitch_valid      = cmd_q.hitch_valid;
  assign cmd.hitch_height     = cmd_q.hitch_height;
  assign cmd.hitch_tilt       = cmd_q.hitch_tilt;

  `JTCE_ASSERT_SAME(a_stop_press_quiet, cmd_valid && (cmd_q.estop_cmd == ESTOP_ASSERT), (cmd_q.activate_cmd == ACT_DEACTIVATE) && !cmd_q.user_input_pulse && !cmd_q.behavior_valid && !cmd_q.drive_valid && !cmd_q.hitch_valid, "stop press result carries more than the stop")
  `JTCE_ASSERT_SAME(a_hitch_needs_active, cmd_valid && cmd_q.hitch_valid, st_q.activated && !st_q.stop_latched, "hitch change issued while stopped or inactive")
  `JTCE_ASSERT_NEXT(a_state_hold, !advance, $stable(st_q), "command state changed without a sample moving")
  `JTCE_ASSERT_NEXT(a_result_loaded, advance, cmd_valid, "sample advanced but no result presented")

endmodule

// ===== dv/jtce_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jtce_checker
// Watches the sample, command and configuration channels of the joystick
// teleop command engine, predicts one command record per accepted sample
// and compares every accepted command against the oldest prediction.
// ----------------------------------------------------------------------------
module jtce_checker
  import jtce_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  jtce_sample_if        smp,
  jtce_cmd_if           res,
  jtce_cfg_if           wr,
  output int            fail_count,
  output int            outstanding
);

  localparam int ACC_TOP    = 2 ** (ACC_W - 1) - 1;
  localparam int ACC_BOTTOM = -(2 ** (ACC_W - 1));

  jtce_cfg_t   regs;
  jtce_state_t st;
  jtce_cmd_t   pending_cmds[$];
  int          mismatches = 0;

  function automatic logic signed [ACC_W-1:0] saturate_step(
    input logic signed [ACC_W-1:0] acc,
    input int                      delta
  );
    int sum;
    sum = int'(acc) + delta;
    if (sum > ACC_TOP) sum = ACC_TOP;
    if (sum < ACC_BOTTOM) sum = ACC_BOTTOM;
    return sum[ACC_W-1:0];
  endfunction

  // Advance the command state by one sample and build the record it causes.
  function automatic jtce_cmd_t predict_command(input jtce_sample_t s);
    jtce_cmd_t               c;
    logic                    ep, ap, up, rp, lp, tu, td;
    logic [BCNT_W-1:0]       span;
    logic [BCNT_W-1:0]       bumped;
    logic signed [ACC_W-1:0] nh, nt;
    c  = '0;
    ep = s.buttons[regs.estop_idx];
    ap = s.buttons[regs.activate_idx];
    up = s.buttons[regs.user_idx];
    if (ep && !st.estop_armed && !st.estop_held) begin
      // fresh stop press: latch and report, nothing else is looked at
      st.stop_latched = 1'b1;
      st.estop_held   = 1'b1;
      c.activate_cmd  = ACT_DEACTIVATE;
      c.estop_cmd     = ESTOP_ASSERT;
    end else begin
      if (!ep && !st.estop_armed && st.estop_held) begin
        st.activated   = 1'b0;
        st.estop_armed = 1'b1;
        st.estop_held  = 1'b0;
      end else if (ep && st.estop_armed && !st.estop_held) begin
        st.stop_latched = 1'b0;
        c.estop_cmd     = ESTOP_RELEASE;
        st.estop_held   = 1'b1;
      end else if (!ep && st.estop_armed && st.estop_held) begin
        st.estop_armed = 1'b0;
        st.estop_held  = 1'b0;
      end

      if (up && !st.user_held) begin
        c.user_input_pulse = 1'b1;
        st.user_held       = 1'b1;
      end else if (!up && st.user_held) begin
        st.user_held = 1'b0;
      end

      if (!st.stop_latched) begin
        if (s.behavior_axis != '0 && !st.axis_held) begin
          span = regs.behavior_count;
          if (span > BCNT_W'(MAX_BEHAVIORS_DEF)) span = BCNT_W'(MAX_BEHAVIORS_DEF);
          if (span > BCNT_W'(IndexSpan)) span = BCNT_W'(IndexSpan);
          // an index left beyond a shrunken count stays put
          if (span != '0 && {1'b0, st.current_behavior} < span) begin
            if (!s.behavior_axis[AXIS_W-1]) begin
              bumped = {1'b0, st.current_behavior} + 1'b1;
              st.current_behavior = (bumped == span) ? '0 : bumped[BIDX_W-1:0];
            end else if (st.current_behavior == '0) begin
              st.current_behavior = BIDX_W'(span - 1'b1);
            end else begin
              st.current_behavior = st.current_behavior - 1'b1;
            end
            c.behavior_valid = 1'b1;
          end
          st.axis_held = 1'b1;
        end else if (s.behavior_axis == '0 && st.axis_held) begin
          st.axis_held = 1'b0;
        end

        if (ap && !st.activate_held) begin
          c.activate_cmd   = st.activated ? ACT_DEACTIVATE : ACT_ACTIVATE;
          st.activate_held = 1'b1;
        end else if (!ap && st.activate_held) begin
          st.activated     = !st.activated;
          st.activate_held = 1'b0;
        end

        if (st.activated) begin
          if (s.turn_axis != st.last_turn || s.speed_axis != st.last_speed) begin
            st.last_turn  = s.turn_axis;
            st.last_speed = s.speed_axis;
            c.drive_valid = 1'b1;
          end
          if (s.raise_trigger != '0 && s.lower_trigger != '0) begin
            // rest is the largest positive value, so anything else is below it
            rp = (s.raise_trigger != TRIGGER_REST);
            lp = (s.lower_trigger != TRIGGER_REST);
            tu = s.buttons[TILT_UP_BIT];
            td = s.buttons[TILT_DOWN_BIT];
            nh = st.height_acc;
            nt = st.tilt_acc;
            if (rp && !lp) nh = saturate_step(nh, int'(HEIGHT_STEP));
            else if (lp && !rp) nh = saturate_step(nh, -int'(HEIGHT_STEP));
            if (tu && !td) nt = saturate_step(nt, int'(TILT_STEP));
            else if (td && !tu) nt = saturate_step(nt, -int'(TILT_STEP));
            if (nh != st.height_acc || nt != st.tilt_acc) c.hitch_valid = 1'b1;
            st.height_acc = nh;
            st.tilt_acc   = nt;
          end
        end
      end
    end
    c.behavior_index = st.current_behavior;
    c.drive_turn     = st.last_turn;
    c.drive_speed    = st.last_speed;
    c.hitch_height   = st.height_acc;
    c.hitch_tilt     = st.tilt_acc;
    return c;
  endfunction

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
               $time, field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    jtce_sample_t s;
    jtce_cmd_t    got;
    jtce_cmd_t    want;
    if (rst) begin
      regs = '{estop_idx: RST_ESTOP_IDX, activate_idx: RST_ACTIVATE_IDX,
               user_idx: RST_USER_IDX, behavior_count: RST_BEH_COUNT};
      st   = '0;
      pending_cmds.delete();
    end else begin
      if (wr.valid && wr.ready) begin
        case (wr.index)
          CFG_ESTOP_IDX:    regs.estop_idx      = wr.data[BIDX_W-1:0];
          CFG_ACTIVATE_IDX: regs.activate_idx   = wr.data[BIDX_W-1:0];
          CFG_USER_IDX:     regs.user_idx       = wr.data[BIDX_W-1:0];
          CFG_BEH_COUNT:    regs.behavior_count = wr.data[BCNT_W-1:0];
          default: ;
        endcase
      end

      // compare before queuing: a result never belongs to the same edge's sample
      if (res.valid && res.ready) begin
        if (pending_cmds.size() == 0) begin
          $display("%0t ns: command transfer with no sample waiting, actual 0x%0h",
                   $time, {res.activate_cmd, res.estop_cmd, res.user_input_pulse,
                           res.behavior_valid, res.behavior_index});
          mismatches++;
        end else begin
          want = pending_cmds.pop_front();
          got  = '{activate_cmd: res.activate_cmd, estop_cmd: res.estop_cmd,
                   user_input_pulse: res.user_input_pulse,
                   behavior_valid: res.behavior_valid,
                   behavior_index: res.behavior_index,
                   drive_valid: res.drive_valid, drive_turn: res.drive_turn,
                   drive_speed: res.drive_speed, hitch_valid: res.hitch_valid,
                   hitch_height: res.hitch_height, hitch_tilt: res.hitch_tilt};
          check_field("activate_cmd", want.activate_cmd, got.activate_cmd);
          check_field("estop_cmd", want.estop_cmd, got.estop_cmd);
          check_field("user_input_pulse", want.user_input_pulse, got.user_input_pulse);
          check_field("behavior_valid", want.behavior_valid, got.behavior_valid);
          check_field("behavior_index", want.behavior_index, got.behavior_index);
          check_field("drive_valid", want.drive_valid, got.drive_valid);
          check_field("drive_turn", want.drive_turn, got.drive_turn);
          check_field("drive_speed", want.drive_speed, got.drive_speed);
          check_field("hitch_valid", want.hitch_valid, got.hitch_valid);
          check_field("hitch_height", want.hitch_height, got.hitch_height);
          check_field("hitch_tilt", want.hitch_tilt, got.hitch_tilt);
        end
      end

      if (smp.valid && smp.ready) begin
        s = '{buttons: smp.buttons, behavior_axis: smp.behavior_axis,
              turn_axis: smp.turn_axis, speed_axis: smp.speed_axis,
              raise_trigger: smp.raise_trigger, lower_trigger: smp.lower_trigger};
        pending_cmds.push_back(predict_command(s));
      end
    end
    outstanding <= pending_cmds.size();
    fail_count  <= mismatches;
  end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives joystick samples and register writes into the teleop command
// engine: a directed walk through stop, activation, behavior and hitch
// handling, then random phases under several register settings with
// random sender gaps and receiver stalls. The checker judges the commands.
// ----------------------------------------------------------------------------
module tb_top;
  import jtce_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 1500;
  localparam int PHASES       = 8;

  localparam logic signed [AXIS_W-1:0] AXIS_MAX = 16'sd32767;
  localparam logic signed [AXIS_W-1:0] AXIS_MIN = -16'sd32767;

  // buttons under the reset register settings
  localparam logic [BTN_W-1:0] ESTOP_BTN = BTN_W'(1) << RST_ESTOP_IDX;
  localparam logic [BTN_W-1:0] ACT_BTN   = BTN_W'(1) << RST_ACTIVATE_IDX;
  localparam logic [BTN_W-1:0] USER_BTN  = BTN_W'(1) << RST_USER_IDX;
  localparam logic [BTN_W-1:0] TILT_UP   = BTN_W'(1) << TILT_UP_BIT;
  localparam logic [BTN_W-1:0] TILT_DN   = BTN_W'(1) << TILT_DOWN_BIT;
  localparam logic [BTN_W-1:0] NO_BTN    = '0;
  localparam logic [BTN_W-1:0] ALL_BTN   = '1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;
  logic long_hold = 1'b0;
  int   hold_cnt = 0;
  int   stall_pct = 0;
  int   idle_pct = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   outstanding;

  logic [BTN_W-1:0]         stick_buttons = '0;
  logic signed [AXIS_W-1:0] stick_turn = '0;
  logic signed [AXIS_W-1:0] stick_speed = '0;

  logic [CFG_AW-1:0] reg_order [4] = '{CFG_ESTOP_IDX, CFG_ACTIVATE_IDX,
                                       CFG_USER_IDX, CFG_BEH_COUNT};
  // e-stop index, activate index, user index, behavior count
  logic [CFG_DW-1:0] cfg_plan [PHASES][4] = '{
    '{5'd15, 5'd0,  5'd7,  5'd16},
    '{5'd0,  5'd15, 5'd15, 5'd5},
    '{5'd9,  5'd2,  5'd12, 5'd0},
    '{5'd30, 5'd22, 5'd17, 5'd31},
    '{5'd3,  5'd8,  5'd0,  5'd2},
    '{5'd1,  5'd0,  5'd3,  5'd1},
    '{5'd4,  5'd5,  5'd6,  5'd16},
    '{5'd11, 5'd13, 5'd13, 5'd3}
  };
  int idle_plan [4]  = '{0, 50, 0, 24};
  int stall_plan [4] = '{0, 0, 50, 24};

  jtce_sample_if sample_ch ();
  jtce_cmd_if    cmd_ch ();
  jtce_cfg_if    cfg_ch ();

  assign cmd_ch.ready = sink_ready;

  joystick_teleop_command_engine uut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch),
    .cmd    (cmd_ch),
    .cfg    (cfg_ch)
  );

  jtce_checker cmd_check (
    .clk         (clk),
    .rst         (rst),
    .smp         (sample_ch),
    .res         (cmd_ch),
    .wr          (cfg_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Hold off for a long stretch while long_hold is up, else stall at random.
  always @(posedge clk) begin
    if (rst) begin
      sink_ready <= 1'b0;
      hold_cnt   <= 0;
    end else if (long_hold && hold_cnt < HOLD_CYCLES) begin
      sink_ready <= 1'b0;
      hold_cnt   <= hold_cnt + 1;
    end else begin
      sink_ready <= ($urandom_range(99) >= stall_pct);
      if (!long_hold) hold_cnt <= 0;
    end
  end

  function automatic jtce_sample_t make_sample(
    input logic [BTN_W-1:0] b, input logic [AXIS_W-1:0] bx, input logic [AXIS_W-1:0] tn,
    input logic [AXIS_W-1:0] sp, input logic [AXIS_W-1:0] rs, input logic [AXIS_W-1:0] lw
  );
    return '{buttons: b, behavior_axis: bx, turn_axis: tn, speed_axis: sp,
             raise_trigger: rs, lower_trigger: lw};
  endfunction

  function automatic logic [AXIS_W-1:0] rand_axis();
    case ($urandom_range(9))
      0:       return '0;
      1:       return AXIS_MAX;
      2:       return AXIS_MIN;
      default: return AXIS_W'(int'($urandom_range(65534)) - 32767);
    endcase
  endfunction

  function automatic logic [AXIS_W-1:0] rand_trigger();
    int p;
    p = $urandom_range(9);
    if (p < 6) return TRIGGER_REST;
    else if (p < 9) return rand_axis();
    else return '0;
  endfunction

  task automatic send_sample(input jtce_sample_t s);
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid <= 1'b0;
      @(posedge clk);
    end
    sample_ch.valid         <= 1'b1;
    sample_ch.buttons       <= s.buttons;
    sample_ch.behavior_axis <= s.behavior_axis;
    sample_ch.turn_axis     <= s.turn_axis;
    sample_ch.speed_axis    <= s.speed_axis;
    sample_ch.raise_trigger <= s.raise_trigger;
    sample_ch.lower_trigger <= s.lower_trigger;
    do @(posedge clk); while (!sample_ch.ready);
  endtask

  // Stop sending and wait until every command has come out, plus latency.
  task automatic drain();
    sample_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_phase(input int p);
    for (int r = 0; r < 4; r++) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= reg_order[r];
      cfg_ch.data  <= cfg_plan[p][r];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b0;
  endtask

  // Mostly a stick that changes a few buttons at a time, some pure noise.
  task automatic run_random(input int count, input int est_bit);
    jtce_sample_t s;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 8) begin
        s = make_sample(BTN_W'($urandom), rand_axis(), rand_axis(), rand_axis(),
                        rand_axis(), rand_axis());
      end else begin
        for (int b = 0; b < BTN_W; b++) begin
          if ($urandom_range(99) < ((b == est_bit) ? 2 : 7))
            stick_buttons[b] = ~stick_buttons[b];
        end
        if ($urandom_range(99) < 30) stick_turn = rand_axis();
        if ($urandom_range(99) < 30) stick_speed = rand_axis();
        s = make_sample(stick_buttons, ($urandom_range(1) == 0) ? '0 : rand_axis(),
                        stick_turn, stick_speed, rand_trigger(), rand_trigger());
      end
      send_sample(s);
    end
  endtask

  initial begin
    sample_ch.valid         <= 1'b0;
    sample_ch.buttons       <= '0;
    sample_ch.behavior_axis <= '0;
    sample_ch.turn_axis     <= '0;
    sample_ch.speed_axis    <= '0;
    sample_ch.raise_trigger <= '0;
    sample_ch.lower_trigger <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= CFG_ESTOP_IDX;
    cfg_ch.data             <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed walk under reset register values
    send_sample(make_sample(NO_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(USER_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(USER_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(NO_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(NO_BTN, AXIS_MAX, '0, '0, '0, '0));
    send_sample(make_sample(NO_BTN, AXIS_MIN, '0, '0, '0, '0));
    send_sample(make_sample(NO_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(NO_BTN, AXIS_MIN, '0, '0, '0, '0));
    send_sample(make_sample(ACT_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(NO_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(TILT_UP, '0, AXIS_MAX, AXIS_MIN, TRIGGER_REST, TRIGGER_REST));
    send_sample(make_sample(TILT_DN, '0, AXIS_MAX, AXIS_MIN, AXIS_MIN, TRIGGER_REST));
    send_sample(make_sample(TILT_UP | TILT_DN, '0, AXIS_MIN, AXIS_MAX, TRIGGER_REST,
                            AXIS_MIN));
    send_sample(make_sample(NO_BTN, '0, AXIS_MIN, AXIS_MAX, 16'sd100, 16'sd100));
    send_sample(make_sample(TILT_UP, '0, '0, '0, '0, TRIGGER_REST));
    send_sample(make_sample(TILT_UP, '0, '0, '0, TRIGGER_REST, '0));
    send_sample(make_sample(ACT_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(NO_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(ACT_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(ACT_BTN | ESTOP_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(ALL_BTN, AXIS_MAX, AXIS_MAX, AXIS_MAX, AXIS_MIN, AXIS_MIN));
    send_sample(make_sample(NO_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(ESTOP_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(NO_BTN, '0, '0, '0, '0, '0));
    send_sample(make_sample(ALL_BTN, AXIS_MAX, AXIS_MAX, AXIS_MAX, TRIGGER_REST,
                            TRIGGER_REST));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      program_phase(p);
      idle_pct = idle_plan[p % 4];
      stall_pct <= stall_plan[p % 4];
      if (p == 4) begin
        // fill the block against a long receiver hold-off, then let it drain
        idle_pct = 0;
        stall_pct <= 0;
        long_hold <= 1'b1;
        run_random(40, cfg_plan[p][0][BIDX_W-1:0]);
        long_hold <= 1'b0;
        drain();
        idle_pct = idle_plan[p % 4];
      end
      run_random(RANDOM_ITEMS / PHASES, cfg_plan[p][0][BIDX_W-1:0]);
    end

    stall_pct <= 0;
    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== joystick_teleop_command_engine.f =====
+incdir+hdl
hdl/jtce_pkg.sv
hdl/jtce_channels.sv
hdl/jtce_cfg_regs.sv
hdl/jtce_step.sv
hdl/joystick_teleop_command_engine.sv
dv/jtce_checker.sv
dv/tb_top.sv
